// ===== rtl/scoped_hash_symbol_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// scoped hash symbol table assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef SCOPED_HASH_SYMBOL_TABLE_UNIT_ASSERT_SVH
`define SCOPED_HASH_SYMBOL_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SHST_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");
// next-cycle implication
`define SHST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`else
`define SHST_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SHST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/shst_pkg.sv =====
// ----------------------------------------------------------------------------
// shst_pkg
// operation and status codes of the scoped hash symbol table
// ----------------------------------------------------------------------------
package shst_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_LOOKUP = 2'd1;
  localparam op_t OP_POP    = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_EMPTY     = 2'd3;

endpackage

// ===== rtl/shst_ram.sv =====
// ----------------------------------------------------------------------------
// shst_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module shst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/shst_hash.sv =====
// ----------------------------------------------------------------------------
// shst_hash
// key mod BUCKETS, eight key bits per cycle, msb first
// ----------------------------------------------------------------------------
module shst_hash #(
  parameter int KEY_WIDTH = 32,
  parameter int BUCKETS   = 127
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [KEY_WIDTH-1:0]       key,
  output logic                       done,
  output logic [$clog2(BUCKETS)-1:0] bucket
);

  localparam int DIGIT      = 8;
  localparam int DIGIT_VALS = 1 << DIGIT;
  localparam int DIGIT_MOD  = DIGIT_VALS % BUCKETS;
  localparam int STEPS      = (KEY_WIDTH + DIGIT - 1) / DIGIT;
  localparam int PAD_W      = STEPS * DIGIT;
  localparam int BKT_W      = $clog2(BUCKETS);
  localparam int RW         = BKT_W + 1;
  localparam int CNT_W      = $clog2(STEPS + 1);
  localparam logic [RW-1:0]    BKT_C    = RW'(BUCKETS);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(STEPS - 1);

  logic [PAD_W-1:0] sh;
  logic [BKT_W-1:0] rem;
  logic [BKT_W-1:0] rem_next;
  logic [BKT_W-1:0] rem_shifted;
  logic [BKT_W-1:0] digit_rem;
  logic [RW-1:0]    sum;
  logic [RW-1:0]    diff;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  // constant tables: (rem * 256) mod BUCKETS and digit mod BUCKETS
  always_comb begin
    int rs;
    int dr;
    rs          = 0;
    dr          = 0;
    rem_shifted = '0;
    digit_rem   = '0;
    for (int i = 0; i < BUCKETS; i++) begin
      if (rem == BKT_W'(i)) begin
        rem_shifted = BKT_W'(rs);
      end
      rs = rs + DIGIT_MOD;
      if (rs >= BUCKETS) begin
        rs = rs - BUCKETS;
      end
    end
    for (int j = 0; j < DIGIT_VALS; j++) begin
      if (sh[PAD_W-1 -: DIGIT] == DIGIT'(j)) begin
        digit_rem = BKT_W'(dr);
      end
      dr = dr + 1;
      if (dr == BUCKETS) begin
        dr = 0;
      end
    end
  end

  // both terms are below BUCKETS, one subtract brings the sum back in range
  assign sum      = {1'b0, rem_shifted} + {1'b0, digit_rem};
  assign diff     = sum - BKT_C;
  assign rem_next = (sum >= BKT_C) ? diff[BKT_W-1:0] : sum[BKT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sh   <= PAD_W'(key);
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        sh  <= sh << DIGIT;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == LAST_CNT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign bucket = rem;

endmodule

// ===== rtl/scoped_hash_symbol_table_unit.sv =====
// ----------------------------------------------------------------------------
// scoped_hash_symbol_table_unit
// scoped symbol table: bucket heads and a stack-shaped binding pool in rams
// ----------------------------------------------------------------------------
// One item is worked at a time and gives one result. Insert and lookup first
// hash the key, then read the bucket head; an insert then writes the new
// binding as the chain head, and a lookup walks the chain, reading the pool
// ram once per link. A pop reads the top pool entry and unlinks it from its
// bucket; a full insert, an empty pop or an unused op code goes straight to
// the result. The next input transfer can be taken in the cycle the result
// appears; a result waits until the result register is free, with in_stall
// held high. After reset the bucket head ram is cleared one bucket per cycle,
// all BUCKETS of them, with in_stall held high.
// ----------------------------------------------------------------------------
`include "scoped_hash_symbol_table_unit_assert.svh"

module scoped_hash_symbol_table_unit #(
  parameter int BUCKETS     = 127,
  parameter int ENTRIES     = 256,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  shst_pkg::op_t          op,
  input  logic [KEY_WIDTH-1:0]   key,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output shst_pkg::status_t      status,
  output logic [VALUE_WIDTH-1:0] found_value,
  output logic [KEY_WIDTH-1:0]   popped_key
);

  import shst_pkg::*;

  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int ADDR_W = $clog2(ENTRIES);
  localparam int PTR_W  = $clog2(ENTRIES + 1);
  localparam logic [PTR_W-1:0] NIL_PTR    = PTR_W'(ENTRIES);
  localparam logic [PTR_W-1:0] LAST_WALK  = PTR_W'(ENTRIES - 1);
  localparam logic [BKT_W-1:0] LAST_BKT   = BKT_W'(BUCKETS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_HEAD  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_POP   = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
    logic [BKT_W-1:0]       bkt;
    logic [PTR_W-1:0]       next;
  } pool_word_t;

  localparam int POOL_W = $bits(pool_word_t);

  logic [2:0]             state;
  logic [BKT_W-1:0]       clr_idx;
  logic [PTR_W-1:0]       count;
  logic [PTR_W-1:0]       count_dec;
  logic [PTR_W-1:0]       walk_cnt;
  op_t                    op_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [BKT_W-1:0]       bkt_r;
  status_t                res_status;
  logic [VALUE_WIDTH-1:0] res_fv;
  logic [KEY_WIDTH-1:0]   res_pk;

  logic                   full;
  logic                   hash_start;
  logic                   hash_done;
  logic [BKT_W-1:0]       hash_bkt;

  logic                   bh_wr_en;
  logic [BKT_W-1:0]       bh_wr_addr;
  logic [PTR_W-1:0]       bh_wr_data;
  logic                   bh_rd_en;
  logic [BKT_W-1:0]       bh_rd_addr;
  logic [PTR_W-1:0]       bh_rd_data;

  logic                   pool_wr_en;
  logic [ADDR_W-1:0]      pool_wr_addr;
  pool_word_t             pool_wr_word;
  logic                   pool_rd_en;
  logic [ADDR_W-1:0]      pool_rd_addr;
  logic [POOL_W-1:0]      pool_rd_data;
  pool_word_t             pool_rd_word;

  logic                   head_ok;
  logic                   next_ok;
  logic                   key_hit;
  logic                   out_free;

  assign full         = (count == NIL_PTR);
  assign count_dec    = count - 1'b1;
  assign pool_rd_word = pool_word_t'(pool_rd_data);
  assign head_ok      = (bh_rd_data < NIL_PTR);
  assign next_ok      = (pool_rd_word.next < NIL_PTR);
  assign key_hit      = (pool_rd_word.key == key_r);
  assign out_free     = !out_valid || !out_stall;
  assign in_stall     = (state != S_IDLE);

  assign hash_start = (state == S_IDLE) && in_valid &&
                      (((op == OP_INSERT) && !full) || (op == OP_LOOKUP));

  shst_hash #(
    .KEY_WIDTH (KEY_WIDTH),
    .BUCKETS   (BUCKETS)
  ) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .key    (key),
    .done   (hash_done),
    .bucket (hash_bkt)
  );

  shst_ram #(
    .WIDTH (PTR_W),
    .DEPTH (BUCKETS)
  ) u_bucket_head (
    .clk     (clk),
    .wr_en   (bh_wr_en),
    .wr_addr (bh_wr_addr),
    .wr_data (bh_wr_data),
    .rd_en   (bh_rd_en),
    .rd_addr (bh_rd_addr),
    .rd_data (bh_rd_data)
  );

  shst_ram #(
    .WIDTH (POOL_W),
    .DEPTH (ENTRIES)
  ) u_pool (
    .clk     (clk),
    .wr_en   (pool_wr_en),
    .wr_addr (pool_wr_addr),
    .wr_data (pool_wr_word),
    .rd_en   (pool_rd_en),
    .rd_addr (pool_rd_addr),
    .rd_data (pool_rd_data)
  );

  // memory port control
  always_comb begin
    bh_wr_en     = 1'b0;
    bh_wr_addr   = bkt_r;
    bh_wr_data   = count;
    bh_rd_en     = 1'b0;
    bh_rd_addr   = hash_bkt;
    pool_wr_en   = 1'b0;
    pool_wr_addr = count[ADDR_W-1:0];
    pool_wr_word = '{key: key_r, value: value_r, bkt: bkt_r, next: bh_rd_data};
    pool_rd_en   = 1'b0;
    pool_rd_addr = count_dec[ADDR_W-1:0];
    case (state)
      S_CLEAR: begin
        bh_wr_en   = 1'b1;
        bh_wr_addr = clr_idx;
        bh_wr_data = NIL_PTR;
      end
      S_IDLE: begin
        pool_rd_en = in_valid && (op == OP_POP) && (count != '0);
      end
      S_HASH: begin
        bh_rd_en = hash_done;
      end
      S_HEAD: begin
        if (op_r == OP_INSERT) begin
          // new binding becomes the chain head
          pool_wr_en = 1'b1;
          bh_wr_en   = 1'b1;
        end else begin
          pool_rd_en   = head_ok;
          pool_rd_addr = bh_rd_data[ADDR_W-1:0];
        end
      end
      S_WALK: begin
        pool_rd_en   = !key_hit && next_ok && (walk_cnt != LAST_WALK);
        pool_rd_addr = pool_rd_word.next[ADDR_W-1:0];
      end
      S_POP: begin
        // popped binding is the head of its bucket
        bh_wr_en   = 1'b1;
        bh_wr_addr = pool_rd_word.bkt;
        bh_wr_data = pool_rd_word.next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // in S_RESP the result register is loaded below instead
      if (out_valid && !out_stall && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_BKT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= op;
            key_r      <= key;
            value_r    <= value;
            res_fv     <= '0;
            res_pk     <= '0;
            res_status <= ST_OK;
            case (op)
              OP_INSERT: begin
                if (full) begin
                  res_status <= ST_FULL;
                  state      <= S_RESP;
                end else begin
                  state <= S_HASH;
                end
              end
              OP_LOOKUP: begin
                state <= S_HASH;
              end
              OP_POP: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_RESP;
                end else begin
                  state <= S_POP;
                end
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_HASH: begin
          if (hash_done) begin
            bkt_r <= hash_bkt;
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (op_r == OP_INSERT) begin
            count <= count + 1'b1;
            state <= S_RESP;
          end else if (head_ok) begin
            walk_cnt <= '0;
            state    <= S_WALK;
          end else begin
            res_status <= ST_NOT_FOUND;
            state      <= S_RESP;
          end
        end
        S_WALK: begin
          if (key_hit) begin
            res_fv <= pool_rd_word.value;
            state  <= S_RESP;
          end else if (!next_ok || (walk_cnt == LAST_WALK)) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_RESP;
          end else begin
            walk_cnt <= walk_cnt + 1'b1;
          end
        end
        S_POP: begin
          res_pk <= pool_rd_word.key;
          count  <= count_dec;
          state  <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            status      <= res_status;
            found_value <= res_fv;
            popped_key  <= res_pk;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SHST_ASSERT_NEXT(a_busy_after_transfer, clk, rst, in_valid && !in_stall, in_stall)
  `SHST_ASSERT_IMPLY(a_no_write_when_full, clk, rst, pool_wr_en, count < NIL_PTR)
  `SHST_ASSERT_NEXT(a_result_shown, clk, rst, state == S_RESP && out_free, out_valid)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scoped hash symbol table. It drives inserts,
// lookups, pops and the unused op code, with random gaps and output stalls.
// Every accepted request is run through an in-bench table model, and each
// response is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
import shst_pkg::*;

localparam int NUM_BUCKETS = 127;
localparam int NUM_ENTRIES = 256;
localparam int NIL_INDEX   = NUM_ENTRIES;

localparam op_t OP_UNUSED = 2'd3;

typedef struct {
  status_t     status;
  logic [31:0] found_value;
  logic [31:0] popped_key;
} symtab_response_t;

class symtab_scoreboard;
  int          bucket_head [NUM_BUCKETS];
  logic [31:0] entry_key   [NUM_ENTRIES];
  logic [31:0] entry_value [NUM_ENTRIES];
  int          entry_next  [NUM_ENTRIES];
  int          count;
  int          errors;
  symtab_response_t expected_responses [$];

  function new();
    foreach (bucket_head[i]) bucket_head[i] = NIL_INDEX;
    foreach (entry_key[i]) begin
      entry_key[i]   = '0;
      entry_value[i] = '0;
      entry_next[i]  = NIL_INDEX;
    end
    count  = 0;
    errors = 0;
  endfunction

  // work out the response to one accepted request and update the table
  function void note_request(op_t o, logic [31:0] k, logic [31:0] v);
    symtab_response_t r;
    int h;
    int p;
    int steps;
    r.status      = ST_OK;
    r.found_value = '0;
    r.popped_key  = '0;
    case (o)
      OP_INSERT: begin
        if (count >= NUM_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          h = int'(k % NUM_BUCKETS);
          entry_key[count]   = k;
          entry_value[count] = v;
          entry_next[count]  = bucket_head[h];
          bucket_head[h]     = count;
          count++;
        end
      end
      OP_LOOKUP: begin
        h        = int'(k % NUM_BUCKETS);
        p        = bucket_head[h];
        steps    = 0;
        r.status = ST_NOT_FOUND;
        while (p < NUM_ENTRIES && steps < NUM_ENTRIES) begin
          if (entry_key[p] == k) begin
            r.status      = ST_OK;
            r.found_value = entry_value[p];
            break;
          end
          p = entry_next[p];
          steps++;
        end
      end
      OP_POP: begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          count--;
          h = int'(entry_key[count] % NUM_BUCKETS);
          bucket_head[h] = entry_next[count];
          r.popped_key   = entry_key[count];
        end
      end
      default: ;
    endcase
    expected_responses.push_back(r);
  endfunction

  function void check_response(status_t st, logic [31:0] fv, logic [31:0] pk);
    symtab_response_t want;
    if (expected_responses.size() == 0) begin
      $error("response with nothing expected: status %0d found_value %h popped_key %h",
             st, fv, pk);
      errors++;
      return;
    end
    want = expected_responses.pop_front();
    if (st !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, st);
      errors++;
    end
    if (fv !== want.found_value) begin
      $error("found_value: expected %h, actual %h", want.found_value, fv);
      errors++;
    end
    if (pk !== want.popped_key) begin
      $error("popped_key: expected %h, actual %h", want.popped_key, pk);
      errors++;
    end
  endfunction

  function int pending();
    return expected_responses.size();
  endfunction
endclass

module tb_top;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  op_t         op;
  logic [31:0] key;
  logic [31:0] value;
  logic        out_valid;
  logic        out_stall;
  status_t     status;
  logic [31:0] found_value;
  logic [31:0] popped_key;

  symtab_scoreboard sb;
  bit               no_gaps;
  int               n_sent;

  scoped_hash_symbol_table_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_value (found_value),
    .popped_key  (popped_key)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // keys crowd a few buckets so chains get long and bindings shadow each other
  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 32'($urandom_range(0, 7) * NUM_BUCKETS + $urandom_range(0, 3));
    if (r < 70) return $urandom;
    if (r < 80) return 32'hFFFF_FFFF - 32'($urandom_range(0, 2) * NUM_BUCKETS);
    if (sb.count > 0) return sb.entry_key[$urandom_range(0, sb.count - 1)];
    return $urandom;
  endfunction

  function automatic logic [31:0] lookup_key();
    if (sb.count > 0 && $urandom_range(0, 99) < 60)
      return sb.entry_key[$urandom_range(0, sb.count - 1)];
    return pick_key();
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_item(input op_t o, input logic [31:0] k, input logic [31:0] v);
    int gap;
    if (n_sent % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    key      <= k;
    value    <= v;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_request(o, k, v);
    n_sent++;
  endtask

  task automatic send_random(input int ins_w, input int look_w, input int pop_w);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < ins_w) send_item(OP_INSERT, pick_key(), pick_value());
    else if (r < ins_w + look_w) send_item(OP_LOOKUP, lookup_key(), $urandom);
    else if (r < ins_w + look_w + pop_w) send_item(OP_POP, $urandom, $urandom);
    else send_item(OP_UNUSED, pick_key(), pick_value());
  endtask

  // result side: random stall before each transfer
  initial begin
    int gap;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_response(status, found_value, popped_key);
  end

  initial begin
    sb       = new();
    no_gaps  = 1'b0;
    n_sent   = 0;
    rst      = 1'b1;
    in_valid = 1'b0;
    op       = OP_INSERT;
    key      = '0;
    value    = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, one shared bucket, shadowing, unused op code
    send_item(OP_POP,    32'h0000_0000, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_INSERT, 32'h0000_0000, 32'h0000_0001);
    send_item(OP_INSERT, 32'd127,       32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'd127,       32'h0000_0000);
    send_item(OP_LOOKUP, 32'd254,       32'h0000_0000);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
    send_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_POP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_POP,    32'h0000_0000, 32'h0000_0000);
    send_item(OP_POP,    32'h0000_0000, 32'h0000_0000);
    send_item(OP_POP,    32'h0000_0000, 32'h0000_0000);
    send_item(OP_POP,    32'h0000_0000, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'd127,       32'h0000_0000);

    repeat (150) send_random(40, 40, 17);

    // fill the pool, then push past full
    while (sb.count < NUM_ENTRIES) begin
      send_item(OP_INSERT, pick_key(), pick_value());
      if ($urandom_range(0, 3) == 0) send_item(OP_LOOKUP, lookup_key(), $urandom);
    end
    repeat (3) send_item(OP_INSERT, pick_key(), pick_value());
    send_item(OP_LOOKUP, lookup_key(), $urandom);

    // drain to empty, then pop past empty
    while (sb.count > 0) begin
      send_item(OP_POP, $urandom, $urandom);
      if ($urandom_range(0, 4) == 0) send_item(OP_LOOKUP, lookup_key(), $urandom);
    end
    repeat (2) send_item(OP_POP, $urandom, $urandom);
    send_item(OP_LOOKUP, lookup_key(), $urandom);

    while (n_sent < 720) send_random(45, 35, 17);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
